[rtl/core/ctpl_pkg.sv]
// ----------------------------------------------------------------------------
// ctpl_pkg
// Shared types, constants and helpers of the cascaded two-pole lowpass.
// ----------------------------------------------------------------------------
package ctpl_pkg;

  localparam int unsigned TAN_DEPTH = 256;
  localparam int unsigned TAN_IDX_W = $clog2(TAN_DEPTH);
  localparam int unsigned POS_W = TAN_IDX_W + 16;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned DIV_Q_W = 40;

  localparam logic [17:0] FS_RESET = 18'd48000;
  localparam logic [17:0] FS_MIN = 18'd8000;
  localparam logic [17:0] FS_MAX = 18'd192000;
  localparam logic [14:0] F_MIN = 15'd20;
  localparam logic [14:0] F_MAX = 15'd20000;
  localparam logic [14:0] Q_MIN = 15'd4096;
  localparam logic [14:0] Q_MAX = 15'd20480;
  localparam logic [24:0] RECIP_100 = 25'd21474837;
  localparam logic [38:0] TAN_CAP = 39'h7F_FFFF_FFFF;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef logic [38:0] tan_arr_t [TAN_DEPTH+1];

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [5:0]           nbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          g_int;
    logic [GAIN_W-1:0]          g_cas;
    logic [GAIN_W-1:0]          g_dir;
  } coef_t;

  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo, rmd;
    quo = 0;
    rmd = 0;
    for (int i = 63; i >= 0; i--) begin
      rmd = {rmd[62:0], num[i]};
      if (rmd >= den) begin
        rmd = rmd - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tan_arr_t build_tan();
    tan_arr_t tab;
    longint unsigned th, th2, ts, tc, t;
    longint s, c;
    for (int unsigned k = 0; k <= TAN_DEPTH; k++) begin
      th = udiv64(PI_Q30 * longint'(k), 2 * longint'(TAN_DEPTH));
      th2 = (th * th) >> 30;
      s = longint'(th);
      c = longint'(ONE_Q30);
      ts = th;
      tc = ONE_Q30;
      for (longint unsigned n = 1; n <= 12; n++) begin
        ts = udiv64((ts * th2) >> 30, (2 * n) * (2 * n + 1));
        tc = udiv64((tc * th2) >> 30, (2 * n - 1) * (2 * n));
        if (n[0]) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      if (s < 0) s = 0;
      if (s > longint'(2 * ONE_Q30)) s = longint'(2 * ONE_Q30);
      if (c <= 0) begin
        tab[k] = TAN_CAP;
      end else begin
        t = udiv64(unsigned'(s) << 32, unsigned'(c));
        tab[k] = (t > 64'(TAN_CAP)) ? TAN_CAP : t[38:0];
      end
    end
    return tab;
  endfunction

  localparam tan_arr_t TAN_TAB = build_tan();

  function automatic logic signed [39:0] sat40(logic signed [47:0] v);
    if (v > 48'sh007F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
    if (v < -48'sh0080_0000_0000) return -40'sh80_0000_0000;
    return v[39:0];
  endfunction

endpackage

[rtl/core/ctpl_div.sv]
// ----------------------------------------------------------------------------
// ctpl_div
// Restoring divider, one quotient bit per cycle, quotient length per request.
// ----------------------------------------------------------------------------
module ctpl_div import ctpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [33:0]          rem_q, rem_d;
  logic [DIV_NUM_W-1:0] sh_q, sh_d;
  logic [DIV_Q_W-1:0]   quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [34:0]          trial;
  logic                 ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    sh_d = sh_q;
    quo_d = quo_q;
    den_d = den_q;
    trial = {rem_q, sh_q[DIV_NUM_W-1]};
    ge = (trial >= 35'(den_q));
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = req_i.nbits;
      rem_d = 34'(req_i.num >> req_i.nbits);
      sh_d = req_i.num << (7'd64 - 7'(req_i.nbits));
      quo_d = '0;
      den_d = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? 34'(trial - 35'(den_q)) : trial[33:0];
      quo_d = {quo_q[DIV_Q_W-2:0], ge};
      sh_d = sh_q << 1;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q <= sh_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && $past(busy_q)) |-> (35'(rem_q) < 35'(den_q)))
    else $error("partial remainder not below divisor");

endmodule

[rtl/core/ctpl_coef.sv]
// ----------------------------------------------------------------------------
// ctpl_coef
// Front end: takes a word, clamps its controls and derives the three gains.
// ----------------------------------------------------------------------------
module ctpl_coef import ctpl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [17:0]                fs_i,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic [14:0]                cutoff_hz_i,
  input  logic [14:0]                resonance_q_i,
  output logic                       cq_push_o,
  input  logic                       cq_full_i,
  output coef_t                      cq_data_o
);

  localparam logic [3:0] S_IDLE = 4'd0, S_FM1 = 4'd1, S_FM2 = 4'd2, S_POS = 4'd3,
                         S_POSW = 4'd4, S_TAB = 4'd5, S_INTP = 4'd6, S_WN = 4'd7,
                         S_WSQ = 4'd8, S_DAMPW = 4'd9, S_GI = 4'd10, S_GIW = 4'd11,
                         S_GC = 4'd12, S_GCW = 4'd13, S_GD = 4'd14, S_PUSH = 4'd15;

  logic [3:0]                 state_q, state_d;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [14:0]                f_q, q_q;
  logic [17:0]                fs_q, fs_c;
  logic [23:0]                p49_q;
  logic [POS_W-1:0]           pos_q;
  logic [38:0]                t0_q, t1_q, wn_q, damp_q;
  logic [16:0]                frac_q;
  logic                       up_q;
  logic [55:0]                prod_q;
  logic [45:0]                wsq_q;
  logic [41:0]                wq_q;
  logic [GAIN_W-1:0]          gint_q, gcas_q, gdir_q;
  logic [48:0]                fm_prod;
  logic [17:0]                fmax;
  logic [38:0]                diff;
  logic [39:0]                t_sum;
  logic [40:0]                w2;
  logic [61:0]                sq_prod, gd_prod;
  logic [53:0]                wq_prod;
  logic [46:0]                gsum;
  logic [44:0]                dent;
  logic [42:0]                wq1;
  logic [TAN_IDX_W-1:0]       idx;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  ctpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    fs_c = fs_i;
    if (fs_i < FS_MIN) fs_c = FS_MIN;
    if (fs_i > FS_MAX) fs_c = FS_MAX;
    fm_prod = 49'(p49_q) * 49'(RECIP_100);
    fmax = fm_prod[48:31];
    idx = pos_q[POS_W-1:16];
    diff = up_q ? (t1_q - t0_q) : (t0_q - t1_q);
    t_sum = up_q ? (40'(t0_q) + 40'(prod_q >> 16)) : (40'(t0_q) - 40'(prod_q >> 16));
    w2 = {t_sum, 1'b0};
    sq_prod = 62'(wn_q[38:8]) * 62'(wn_q[38:8]);
    wq_prod = 54'(wn_q) * 54'(q_q);
    gsum = 47'(damp_q) + 47'(wsq_q);
    dent = 45'(64'h1_0000_0000) + 45'(damp_q >> 1) + 45'(wsq_q >> 2);
    wq1 = 43'(64'h1_0000_0000) + 43'(wq_q);
    gd_prod = 62'(gint_q) * 62'(gcas_q);
    div_req = '0;
    case (state_q)
      S_POS: begin
        div_req.start = 1'b1;
        div_req.num = 64'(f_q) << (TAN_IDX_W + 17);
        div_req.den = DIV_DEN_W'(fs_q);
        div_req.nbits = 6'(POS_W);
      end
      S_WSQ: begin
        div_req.start = 1'b1;
        div_req.num = 64'(wn_q) << 12;
        div_req.den = DIV_DEN_W'(q_q);
        div_req.nbits = 6'd39;
      end
      S_GI: begin
        div_req.start = 1'b1;
        div_req.num = 64'(gsum) << 16;
        div_req.den = DIV_DEN_W'(dent >> 12);
        div_req.nbits = 6'd32;
      end
      S_GC: begin
        div_req.start = 1'b1;
        div_req.num = 64'(wq_q) << 16;
        div_req.den = DIV_DEN_W'(wq1 >> 12);
        div_req.nbits = 6'd30;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (push) state_d = S_FM1;
      S_FM1: state_d = S_FM2;
      S_FM2: state_d = S_POS;
      S_POS: state_d = S_POSW;
      S_POSW: if (div_rsp.done) state_d = S_TAB;
      S_TAB: state_d = S_INTP;
      S_INTP: state_d = S_WN;
      S_WN: state_d = S_WSQ;
      S_WSQ: state_d = S_DAMPW;
      S_DAMPW: if (div_rsp.done) state_d = S_GI;
      S_GI: state_d = S_GIW;
      S_GIW: if (div_rsp.done) state_d = S_GC;
      S_GC: state_d = S_GCW;
      S_GCW: if (div_rsp.done) state_d = S_GD;
      S_GD: state_d = S_PUSH;
      S_PUSH: if (!cq_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        smp_q <= in_sample_i;
        fs_q <= fs_c;
        f_q <= (cutoff_hz_i < F_MIN) ? F_MIN : (cutoff_hz_i > F_MAX) ? F_MAX : cutoff_hz_i;
        q_q <= (resonance_q_i < Q_MIN) ? Q_MIN :
               (resonance_q_i > Q_MAX) ? Q_MAX : resonance_q_i;
      end
      S_FM1: p49_q <= 24'(fs_q) * 24'd49;
      S_FM2: if (18'(f_q) > fmax) f_q <= 15'(fmax);
      S_POSW: if (div_rsp.done) pos_q <= div_rsp.quot[POS_W-1:0];
      S_TAB: begin
        t0_q <= TAN_TAB[(TAN_IDX_W+1)'(idx)];
        t1_q <= TAN_TAB[(TAN_IDX_W+1)'(idx) + 1'b1];
        frac_q <= 17'(pos_q[15:0]);
        up_q <= (TAN_TAB[(TAN_IDX_W+1)'(idx) + 1'b1] >= TAN_TAB[(TAN_IDX_W+1)'(idx)]);
      end
      S_INTP: prod_q <= 56'(diff) * 56'(frac_q);
      S_WN: wn_q <= (w2 > 41'(TAN_CAP)) ? TAN_CAP : w2[38:0];
      S_WSQ: begin
        wsq_q <= 46'(sq_prod >> 16);
        wq_q <= 42'(wq_prod >> 12);
      end
      S_DAMPW: if (div_rsp.done) damp_q <= div_rsp.quot[38:0];
      S_GIW: if (div_rsp.done) gint_q <= div_rsp.quot[GAIN_W-1:0];
      S_GCW: if (div_rsp.done) gcas_q <= div_rsp.quot[GAIN_W-1:0];
      S_GD: gdir_q <= 32'(gd_prod >> 30);
      default: begin
      end
    endcase
  end

  assign full = (state_q != S_IDLE);
  assign cq_push_o = (state_q == S_PUSH) && !cq_full_i;
  assign cq_data_o.sample = smp_q;
  assign cq_data_o.g_int = gint_q;
  assign cq_data_o.g_cas = gcas_q;
  assign cq_data_o.g_dir = gdir_q;

  a_push_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_push_o |-> !cq_full_i) else $error("word pushed into a full queue");

endmodule

[rtl/core/ctpl_cq.sv]
// ----------------------------------------------------------------------------
// ctpl_cq
// Two-entry queue that carries gains and sample from front end to back end.
// ----------------------------------------------------------------------------
module ctpl_cq import ctpl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  coef_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output coef_t data_o
);

  coef_t      ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o = ent_q[rd_q];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue fill count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

[rtl/core/ctpl_filt.sv]
// ----------------------------------------------------------------------------
// ctpl_filt
// Back end: runs the two integrator sections and holds the result word.
// ----------------------------------------------------------------------------
module ctpl_filt import ctpl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cq_empty_i,
  input  coef_t                      cq_data_i,
  output logic                       cq_pop_o,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  localparam logic [2:0] B_IDLE = 3'd0, B_LOAD = 3'd1, B_MHI = 3'd2, B_MLO = 3'd3,
                         B_APPLY = 3'd4, B_OUT = 3'd5;
  localparam logic [1:0] OP_CAS = 2'd0, OP_DIR = 2'd1, OP_INT = 2'd2;

  logic [2:0]                 state_q, state_d;
  logic [1:0]                 op_q;
  logic                       sec_q;
  logic signed [39:0]         ia_q [2];
  logic signed [39:0]         ib_q [2];
  coef_t                      cf_q;
  logic signed [41:0]         u_q, d_q;
  logic signed [39:0]         y_q;
  logic                       neg_q;
  logic [53:0]                phi_q;
  logic [51:0]                plo_q;
  logic [19:0]                mlo_q;
  logic                       ov_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic [GAIN_W-1:0]          g;
  logic signed [41:0]         x;
  logic [41:0]                mag;
  logic [46:0]                r;
  logic signed [47:0]         mg;
  logic signed [31:0]         ysh;

  always_comb begin
    case (op_q)
      OP_CAS: g = cf_q.g_cas;
      OP_DIR: g = cf_q.g_dir;
      default: g = cf_q.g_int;
    endcase
    x = (op_q == OP_CAS) ? 42'(ia_q[sec_q]) : d_q;
    mag = x[41] ? 42'(-x) : 42'(x);
    r = 47'(phi_q >> 8) + 47'((53'({phi_q[7:0], 20'b0}) + 53'(plo_q)) >> 28);
    mg = neg_q ? -48'(r) : 48'(r);
    ysh = 32'(y_q >>> 8);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!cq_empty_i) state_d = B_LOAD;
      B_LOAD: state_d = B_MHI;
      B_MHI: state_d = B_MLO;
      B_MLO: state_d = B_APPLY;
      B_APPLY: begin
        if (op_q != OP_INT) state_d = B_MHI;
        else if (!sec_q) state_d = B_LOAD;
        else state_d = B_OUT;
      end
      B_OUT: if (!ov_q || pop) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      op_q <= OP_CAS;
      sec_q <= 1'b0;
      ov_q <= 1'b0;
      ia_q[0] <= '0;
      ia_q[1] <= '0;
      ib_q[0] <= '0;
      ib_q[1] <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == B_OUT) && (!ov_q || pop)) begin
        ov_q <= 1'b1;
      end else if (pop) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          sec_q <= 1'b0;
        end
        B_LOAD: op_q <= OP_CAS;
        B_APPLY: begin
          case (op_q)
            OP_CAS: begin
              ib_q[sec_q] <= sat40(48'(ib_q[sec_q]) + mg);
              op_q <= OP_DIR;
            end
            OP_DIR: op_q <= OP_INT;
            default: begin
              ia_q[sec_q] <= sat40(48'(ia_q[sec_q]) + mg);
              sec_q <= 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cf_q <= cq_data_i;
        u_q <= 42'(cq_data_i.sample) <<< (32 - SAMPLE_W);
      end
      B_LOAD: d_q <= u_q - 42'(ia_q[sec_q]) - 42'(ib_q[sec_q]);
      B_MHI: begin
        neg_q <= x[41];
        phi_q <= 54'(g) * 54'(mag[41:20]);
        mlo_q <= mag[19:0];
      end
      B_MLO: plo_q <= 52'(g) * 52'(mlo_q);
      B_APPLY: begin
        if (op_q == OP_DIR) y_q <= sat40(mg + 48'(ib_q[sec_q]));
        if (op_q == OP_INT) u_q <= 42'(y_q);
      end
      B_OUT: begin
        if (!ov_q || pop) begin
          if (ysh > 32'sh007F_FFFF) out_q <= 24'sh7F_FFFF;
          else if (ysh < -32'sh0080_0000) out_q <= -24'sh80_0000;
          else out_q <= ysh[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign cq_pop_o = (state_q == B_IDLE) && !cq_empty_i;
  assign empty = !ov_q;
  assign out_sample_o = out_q;

  a_out_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ov_q && $past(state_q) != B_OUT) |=> (!ov_q || $past(state_q) == B_OUT))
    else $error("result word appeared outside the output step");

endmodule

[rtl/core/cascaded_two_pole_lowpass_unit.sv]
// ----------------------------------------------------------------------------
// cascaded_two_pole_lowpass_unit
// Fixed-point 24 dB/octave lowpass built from two trapezoidal state-variable
// sections, with cutoff and resonance given per sample.
// ----------------------------------------------------------------------------
// Each word carries a Q1.23 sample with its cutoff in hertz and resonance in
// Q3.12 and yields one saturated Q1.23 output word. The front end is paced by
// the one-bit-per-cycle divider that forms the table position, the damping
// term and two of the gains (125 quotient bits in all) and is full while busy;
// the back end shares its gain multipliers among its three operations. A
// two-entry queue lets the back end filter one word while the front end works
// on the next. The sample rate register may be written only while idle.
module cascaded_two_pole_lowpass_unit import ctpl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sample_rate_we_i,
  input  logic [17:0]                sample_rate_i,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic [14:0]                cutoff_hz_i,
  input  logic [14:0]                resonance_q_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  logic [17:0] fs_q;
  logic        cq_push, cq_full, cq_pop, cq_empty;
  coef_t       cq_wdata, cq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RESET;
    end else if (sample_rate_we_i) begin
      fs_q <= sample_rate_i;
    end
  end

  ctpl_coef u_coef (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fs_i          (fs_q),
    .push          (push),
    .full          (full),
    .in_sample_i   (in_sample_i),
    .cutoff_hz_i   (cutoff_hz_i),
    .resonance_q_i (resonance_q_i),
    .cq_push_o     (cq_push),
    .cq_full_i     (cq_full),
    .cq_data_o     (cq_wdata)
  );

  ctpl_cq u_cq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_wdata),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .data_o  (cq_rdata)
  );

  ctpl_filt u_filt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cq_empty_i   (cq_empty),
    .cq_data_i    (cq_rdata),
    .cq_pop_o     (cq_pop),
    .empty        (empty),
    .pop          (pop),
    .out_sample_o (out_sample_o)
  );

endmodule
